// ===== hdl/pnfbm_pkg.sv =====
// Shared types, constants and helpers for the 2D octave noise engine.
// Used by every module under hdl/ except pnfbm_div; depends on nothing else.
package pnfbm_pkg;

	// permutation table geometry
	localparam int TABLE_SIZE = 256;
	localparam int TABLE_AW   = $clog2(TABLE_SIZE);

	// shared multiplier operand and product widths
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// fixed-point formats
	localparam int FREQ_W     = 48;
	localparam int FRAC_W     = 16;
	localparam int AMP_W      = 17;
	localparam int CRD_W      = 18;
	localparam int G_W        = 20;
	localparam int D_W        = 22;
	localparam int Q_W        = 22;
	localparam int NOISE_W    = 16;
	localparam int NORM_SHIFT = 14;
	localparam int OCT_CFG_W  = 5;
	localparam int REG_W      = 16;

	localparam logic [AMP_W-1:0]         AMP_ONE   = 17'h10000;
	localparam logic [FREQ_W-1:0]        FREQ_ONE  = 48'h10000;
	localparam logic signed [CRD_W-1:0]  ONE_Q16   = 18'sh10000;
	localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7FFF;
	localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

	// fade polynomial coefficients: 6t^2 - 15t + 10 (Q16)
	localparam logic signed [Q_W-1:0] FADE_C6  = 22'sd6;
	localparam logic signed [Q_W-1:0] FADE_C15 = 22'sd15;
	localparam logic signed [Q_W-1:0] FADE_C10 = 22'sd655360;

	// gradient hash codes
	localparam logic [3:0] HASH_YSEL = 4'd8;
	localparam logic [3:0] HASH_VY   = 4'd4;
	localparam logic [3:0] HASH_X12  = 4'd12;
	localparam logic [3:0] HASH_X14  = 4'd14;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OCTAVES = 2'd0,
		CFG_PERSIST = 2'd1,
		CFG_LACUN   = 2'd2
	} cfg_idx_t;

	// input item kinds
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [OCT_CFG_W-1:0] octave_count;
		logic [REG_W-1:0]     persistence;
		logic [REG_W-1:0]     lacunarity;
	} cfg_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE, ST_SX0, ST_SX1, ST_SY0, ST_SY1, ST_SY2,
		ST_FT2, ST_FT3, ST_FQ, ST_FEND,
		ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6, ST_R7, ST_R8, ST_R9, ST_R10,
		ST_BL1, ST_BL2, ST_BH1, ST_BH2, ST_BV0, ST_BV1, ST_BV2,
		ST_AC0, ST_AC1, ST_AC2, ST_AC3, ST_AC4,
		ST_DIV, ST_DIVW, ST_OUT
	} state_t;

	// 12-direction gradient dot product selected by the low hash nibble
	function automatic logic signed [G_W-1:0] grad_f(
		input logic [7:0]              hash,
		input logic signed [CRD_W-1:0] gx,
		input logic signed [CRD_W-1:0] gy
	);
		logic [3:0]            h;
		logic signed [G_W-1:0] u;
		logic signed [G_W-1:0] v;
		logic signed [G_W-1:0] su;
		logic signed [G_W-1:0] sv;
		h = hash[3:0];
		u = (h < HASH_YSEL) ? G_W'(gx) : G_W'(gy);
		if (h < HASH_VY)
			v = G_W'(gy);
		else if (h == HASH_X12 || h == HASH_X14)
			v = G_W'(gx);
		else
			v = '0;
		su = h[0] ? -u : u;
		sv = h[1] ? -v : v;
		return su + sv;
	endfunction

endpackage

// ===== hdl/pnfbm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pnfbm_pkg for operand widths.
module pnfbm_mul (
	input  logic                                  clk,
	input  logic signed [pnfbm_pkg::MUL_W-1:0]    a,
	input  logic signed [pnfbm_pkg::MUL_W-1:0]    b,
	output logic signed [pnfbm_pkg::PROD_W-1:0]   p
);
	import pnfbm_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	// one product per cycle, result in the next cycle
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== hdl/pnfbm_perm.sv =====
// 256 x 8 permutation memory: one write port, one registered read port.
// Depends on pnfbm_pkg for the table geometry.
module pnfbm_perm (
	input  logic                              clk,
	input  logic                              we,
	input  logic [pnfbm_pkg::TABLE_AW-1:0]    waddr,
	input  logic [7:0]                        wdata,
	input  logic [pnfbm_pkg::TABLE_AW-1:0]    raddr,
	output logic [7:0]                        rdata
);
	import pnfbm_pkg::*;

	logic [7:0] mem [TABLE_SIZE];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/pnfbm_div.sv =====
// Bit-serial restoring divider, signed dividend, unsigned divisor, quotient
// truncated toward zero. Self-contained; imports nothing.
module pnfbm_div #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W:0]   quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [NUM_W-1:0] mag_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             fit;

	// one quotient bit per cycle
	assign rem_sh  = {rem_q, mag_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fit     = (rem_sh >= {1'b0, den_q});

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend magnitude shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			mag_q <= {mag_q[NUM_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// ===== hdl/pnfbm_core.sv =====
// Octave sequencer and datapath: scaling, fade, table hashing, gradients,
// blends and accumulation on one shared multiplier. Uses pnfbm_pkg,
// pnfbm_mul and pnfbm_div; reads the permutation memory through a port.
module pnfbm_core #(
	parameter int MAX_OCTAVES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [31:0]                  x_coord,
	input  logic signed [31:0]                  y_coord,
	input  pnfbm_pkg::cfg_t                     cfg,
	output logic [pnfbm_pkg::TABLE_AW-1:0]      perm_addr,
	input  logic [7:0]                          perm_data,
	output logic                                idle,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [pnfbm_pkg::NOISE_W-1:0] res_data
);
	import pnfbm_pkg::*;

	localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
	localparam int LOG_O = $clog2(MAX_OCTAVES);
	localparam int TOT_W = 20 + LOG_O;
	localparam int SUM_W = 18 + LOG_O;
	localparam int NUM_W = TOT_W + NORM_SHIFT;
	localparam logic signed [NUM_W:0] SAT_HI = (NUM_W + 1)'(NOISE_MAX);
	localparam logic signed [NUM_W:0] SAT_LO = (NUM_W + 1)'(NOISE_MIN);

	state_t state_q, state_d;

	// evaluation state
	logic signed [31:0]       x_q, y_q;
	logic [OCT_W-1:0]         n_q, oct_q, n_d, oct_nx;
	logic [FREQ_W-1:0]        freq_q, flo_q;
	logic [AMP_W-1:0]         amp_q;
	logic signed [TOT_W-1:0]  total_q;
	logic [SUM_W-1:0]         amp_sum_q;
	logic [23:0]              sxl_q, syl_q;
	logic [7:0]               cx_q, cy_q;
	logic [15:0]              fx_q, fy_q, t_q;
	logic                     fsel_q;
	logic signed [Q_W-1:0]    q_q, q_d, t2s, ts;
	logic [AMP_W-1:0]         u_q, v_q;
	logic [7:0]               a_q, b_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [G_W-1:0]    g00_q, g01_q, g10_q, g11_q;
	logic signed [D_W-1:0]    d_q;
	logic signed [G_W-1:0]    lo_q, hi_q, nv_q;
	logic signed [NOISE_W-1:0] res_q;

	// shared unit and divider hookup
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] p;
	logic signed [G_W-1:0]    p_blend;
	logic signed [TOT_W-1:0]  p_contrib;
	logic signed [CRD_W-1:0]  gx0, gx1, gy0, gy1;
	logic [5:0]               oc6;
	logic                     div_start, div_done;
	logic signed [NUM_W:0]    quot;

	pnfbm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p)
	);

	pnfbm_div #(
		.NUM_W (NUM_W),
		.DEN_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ($signed({total_q, {NORM_SHIFT{1'b0}}})),
		.den    (amp_sum_q),
		.done   (div_done),
		.quot   (quot)
	);

	// floor-shifted views of the product
	assign p_blend   = p[FRAC_W +: G_W];
	assign p_contrib = p[FRAC_W +: TOT_W];

	// fade polynomial 6t^2 - 15t + 10 from the fresh t^2
	assign t2s = $signed({6'b0, p[31:16]});
	assign ts  = $signed({6'b0, t_q});
	assign q_d = FADE_C6 * t2s - FADE_C15 * ts + FADE_C10;

	// gradient arguments: fraction and fraction minus one
	assign gx0 = $signed({2'b00, fx_q});
	assign gy0 = $signed({2'b00, fy_q});
	assign gx1 = gx0 - ONE_Q16;
	assign gy1 = gy0 - ONE_Q16;

	// octave count, zero treated as one and limited to the maximum
	assign oc6 = {1'b0, cfg.octave_count};
	always_comb begin
		if (oc6 == 6'd0)
			n_d = OCT_W'(1);
		else if (oc6 > 6'(MAX_OCTAVES))
			n_d = OCT_W'(MAX_OCTAVES);
		else
			n_d = OCT_W'(oc6);
	end
	assign oct_nx = oct_q + OCT_W'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oct_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				oct_q <= '0;
			else if (state_q == ST_AC4)
				oct_q <= oct_nx;
		end
	end

	// next state, multiplier operands, table address, divider start, result valid
	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		perm_addr = '0;
		div_start = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_SX0;
			end
			ST_SX0: begin
				mul_a   = MUL_W'(x_q);
				mul_b   = $signed({1'b0, freq_q[31:0]});
				state_d = ST_SX1;
			end
			ST_SX1: begin
				mul_a   = MUL_W'(x_q);
				mul_b   = $signed({25'b0, freq_q[39:32]});
				state_d = ST_SY0;
			end
			ST_SY0: begin
				mul_a   = MUL_W'(y_q);
				mul_b   = $signed({1'b0, freq_q[31:0]});
				state_d = ST_SY1;
			end
			ST_SY1: begin
				mul_a   = MUL_W'(y_q);
				mul_b   = $signed({25'b0, freq_q[39:32]});
				state_d = ST_SY2;
			end
			ST_SY2: state_d = ST_FT2;
			ST_FT2: begin
				mul_a   = $signed({17'b0, t_q});
				mul_b   = $signed({17'b0, t_q});
				state_d = ST_FT3;
			end
			ST_FT3: begin
				mul_a   = $signed({17'b0, p[31:16]});
				mul_b   = $signed({17'b0, t_q});
				state_d = ST_FQ;
			end
			ST_FQ: begin
				mul_a   = $signed({17'b0, p[31:16]});
				mul_b   = MUL_W'(q_q);
				state_d = ST_FEND;
			end
			ST_FEND: state_d = fsel_q ? ST_R0 : ST_FT2;
			// hashed corner lookups, one read per cycle
			ST_R0: begin
				perm_addr = cx_q;
				state_d   = ST_R1;
			end
			ST_R1: begin
				perm_addr = cx_q + 8'd1;
				state_d   = ST_R2;
			end
			ST_R2: begin
				perm_addr = a_q;
				state_d   = ST_R3;
			end
			ST_R3: begin
				perm_addr = a_q + 8'd1;
				state_d   = ST_R4;
			end
			ST_R4: begin
				perm_addr = b_q;
				state_d   = ST_R5;
			end
			ST_R5: begin
				perm_addr = b_q + 8'd1;
				state_d   = ST_R6;
			end
			ST_R6: begin
				perm_addr = aa_q;
				state_d   = ST_R7;
			end
			ST_R7: begin
				perm_addr = ab_q;
				state_d   = ST_R8;
			end
			ST_R8: begin
				perm_addr = ba_q;
				state_d   = ST_R9;
			end
			ST_R9: begin
				perm_addr = bb_q;
				state_d   = ST_R10;
			end
			ST_R10: state_d = ST_BL1;
			// bilinear blends
			ST_BL1: begin
				mul_a   = $signed({16'b0, u_q});
				mul_b   = MUL_W'(d_q);
				state_d = ST_BL2;
			end
			ST_BL2: state_d = ST_BH1;
			ST_BH1: begin
				mul_a   = $signed({16'b0, u_q});
				mul_b   = MUL_W'(d_q);
				state_d = ST_BH2;
			end
			ST_BH2: state_d = ST_BV0;
			ST_BV0: state_d = ST_BV1;
			ST_BV1: begin
				mul_a   = $signed({16'b0, v_q});
				mul_b   = MUL_W'(d_q);
				state_d = ST_BV2;
			end
			ST_BV2: state_d = ST_AC0;
			// weighting and per-octave updates
			ST_AC0: begin
				mul_a   = MUL_W'(nv_q);
				mul_b   = $signed({16'b0, amp_q});
				state_d = ST_AC1;
			end
			ST_AC1: begin
				mul_a   = $signed({16'b0, amp_q});
				mul_b   = $signed({17'b0, cfg.persistence});
				state_d = ST_AC2;
			end
			ST_AC2: begin
				mul_a   = $signed({1'b0, freq_q[31:0]});
				mul_b   = $signed({17'b0, cfg.lacunarity});
				state_d = ST_AC3;
			end
			ST_AC3: begin
				mul_a   = $signed({17'b0, freq_q[47:32]});
				mul_b   = $signed({17'b0, cfg.lacunarity});
				state_d = ST_AC4;
			end
			ST_AC4: state_d = (oct_nx == n_q) ? ST_DIV : ST_SX0;
			// normalization
			ST_DIV: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW: begin
				if (div_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					x_q       <= x_coord;
					y_q       <= y_coord;
					n_q       <= n_d;
					freq_q    <= FREQ_ONE;
					amp_q     <= AMP_ONE;
					total_q   <= '0;
					amp_sum_q <= '0;
				end
			end
			ST_SX1: sxl_q <= p[39:16];
			ST_SY0: begin
				cx_q <= sxl_q[23:16] + p[7:0];
				fx_q <= sxl_q[15:0];
			end
			ST_SY1: syl_q <= p[39:16];
			ST_SY2: begin
				cy_q   <= syl_q[23:16] + p[7:0];
				fy_q   <= syl_q[15:0];
				t_q    <= fx_q;
				fsel_q <= 1'b0;
			end
			ST_FT3: q_q <= q_d;
			ST_FEND: begin
				if (fsel_q) begin
					v_q <= p[32:16];
				end else begin
					u_q    <= p[32:16];
					t_q    <= fy_q;
					fsel_q <= 1'b1;
				end
			end
			ST_R1:  a_q  <= perm_data + cy_q;
			ST_R2:  b_q  <= perm_data + cy_q;
			ST_R3:  aa_q <= perm_data;
			ST_R4:  ab_q <= perm_data;
			ST_R5:  ba_q <= perm_data;
			ST_R6:  bb_q <= perm_data;
			ST_R7:  g00_q <= grad_f(perm_data, gx0, gy0);
			ST_R8:  g01_q <= grad_f(perm_data, gx0, gy1);
			ST_R9:  g10_q <= grad_f(perm_data, gx1, gy0);
			ST_R10: begin
				g11_q <= grad_f(perm_data, gx1, gy1);
				d_q   <= D_W'(g10_q) - D_W'(g00_q);
			end
			ST_BL2: begin
				lo_q <= g00_q + p_blend;
				d_q  <= D_W'(g11_q) - D_W'(g01_q);
			end
			ST_BH2: hi_q <= g01_q + p_blend;
			ST_BV0: d_q  <= D_W'(hi_q) - D_W'(lo_q);
			ST_BV2: nv_q <= lo_q + p_blend;
			ST_AC1: begin
				total_q   <= total_q + p_contrib;
				amp_sum_q <= amp_sum_q + SUM_W'(amp_q);
			end
			ST_AC2: amp_q <= p[32:16];
			ST_AC3: flo_q <= p[47:0];
			ST_AC4: freq_q <= {p[23:0], 24'b0} + {8'b0, flo_q[47:8]};
			ST_DIVW: begin
				if (quot > SAT_HI)
					res_q <= NOISE_MAX;
				else if (quot < SAT_LO)
					res_q <= NOISE_MIN;
				else
					res_q <= quot[NOISE_W-1:0];
			end
			default: ;
		endcase
	end

	assign idle     = (state_q == ST_IDLE);
	assign res_data = res_q;

endmodule

// ===== hdl/perlin_noise_2d_octaves.sv =====
// 2D improved gradient noise summed over octaves. Each octave is a sequence
// of steps on the shared multiplier and the single table read port; a serial
// normalizing divide follows the last octave. One item is in work at a time.
// Reset clears the sequencer and the output valid flag and loads the register
// defaults; the permutation table holds no value until software writes it.
module perlin_noise_2d_octaves #(
	parameter int MAX_OCTAVES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,   // table_index[7:0], table_value[15:8],
	                                    // x_coord[47:16], y_coord[79:48]
	input  logic        s_axis_tuser,   // cmd
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // noise_value
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pnfbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pnfbm_pkg::REG_W-1:0]     cfg_data
);
	import pnfbm_pkg::*;

	logic                    in_xfer;
	logic                    core_idle;
	logic                    res_valid, res_ready;
	logic signed [NOISE_W-1:0] res_data;
	logic [TABLE_AW-1:0]     perm_addr;
	logic [7:0]              perm_data;
	logic                    out_valid_q;
	logic [NOISE_W-1:0]      out_data_q;
	cfg_t                    cfg_q;

	assign s_axis_tready = core_idle;
	assign in_xfer       = s_axis_tvalid && core_idle;
	assign cfg_ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.octave_count <= OCT_CFG_W'(1);
			cfg_q.persistence  <= 16'd32768;
			cfg_q.lacunarity   <= 16'd512;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OCTAVES: cfg_q.octave_count <= cfg_data[OCT_CFG_W-1:0];
				CFG_PERSIST: cfg_q.persistence  <= cfg_data;
				CFG_LACUN:   cfg_q.lacunarity   <= cfg_data;
				default: ;
			endcase
		end
	end

	pnfbm_perm u_perm (
		.clk   (clk),
		.we    (in_xfer && (s_axis_tuser == CMD_WRITE)),
		.waddr (s_axis_tdata[7:0]),
		.wdata (s_axis_tdata[15:8]),
		.raddr (perm_addr),
		.rdata (perm_data)
	);

	pnfbm_core #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer && (s_axis_tuser == CMD_EVAL)),
		.x_coord   ($signed(s_axis_tdata[47:16])),
		.y_coord   ($signed(s_axis_tdata[79:48])),
		.cfg       (cfg_q),
		.perm_addr (perm_addr),
		.perm_data (perm_data),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
